@@ src/skew_line_closest_midpoint_unit_macros.svh @@
// Assertion macros shared by the skew line midpoint unit.
`ifndef SKEW_LINE_CLOSEST_MIDPOINT_UNIT_MACROS_SVH
`define SKEW_LINE_CLOSEST_MIDPOINT_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define SLCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slcm: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SLCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slcm: next-cycle check failed");
`else
`define SLCM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SLCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/slcm_pkg.sv @@
// Shared widths, pipeline stage indexes and beat types of the skew line midpoint unit.
package slcm_pkg;

    // Coordinate format and multiplier limb size.
    localparam int CW     = 32;
    localparam int LIMB_W = 32;

    // Widths of intermediate values, from the worst-case magnitudes.
    localparam int BA_W  = CW + 1;
    localparam int W_W   = 2 * CW + 1;
    localparam int X_W   = 2 * CW + 2;
    localparam int DEN_W = 4 * CW;
    localparam int SX_W  = 4 * CW + 2;
    localparam int SB_W  = 3 * CW + 2;
    localparam int NUM_W = 5 * CW + 3;

    // Shared multiplier shape.
    localparam int MUL_AW    = SX_W;
    localparam int MUL_BW    = CW + 1;
    localparam int MUL_PW    = MUL_AW + MUL_BW;
    localparam int MUL_LIMBS = (MUL_AW + LIMB_W - 1) / LIMB_W;
    localparam int MUL_LAT   = 5;
    localparam int W_LO      = W_W - MUL_BW;

    // Divider: quotient bits kept before saturation.
    localparam int QB      = CW + 2;
    localparam int DIV_LAT = QB + 3;

    // Register stage indexes of the main pipeline.
    localparam int S_W    = MUL_LAT + 1;
    localparam int S_SUM1 = S_W + MUL_LAT + 1;
    localparam int S_SUM2 = S_SUM1 + 1;
    localparam int S_N    = S_SUM2 + MUL_LAT + 1;
    localparam int S_NUM  = S_N + 1;
    localparam int S_OUT  = S_NUM + DIV_LAT + 1;

    typedef struct packed {
        logic signed [CW-1:0] line_a_start_x;
        logic signed [CW-1:0] line_a_start_y;
        logic signed [CW-1:0] line_a_start_z;
        logic signed [CW-1:0] line_a_dir_x;
        logic signed [CW-1:0] line_a_dir_y;
        logic signed [CW-1:0] line_a_dir_z;
        logic signed [CW-1:0] line_b_start_x;
        logic signed [CW-1:0] line_b_start_y;
        logic signed [CW-1:0] line_b_start_z;
        logic signed [CW-1:0] line_b_dir_x;
        logic signed [CW-1:0] line_b_dir_y;
        logic signed [CW-1:0] line_b_dir_z;
    } t_line_pair;

    typedef struct packed {
        logic signed [CW-1:0] mid_x;
        logic signed [CW-1:0] mid_y;
        logic signed [CW-1:0] mid_z;
        logic                 parallel;
    } t_mid;

endpackage

@@ src/slcm_in_if.sv @@
// Input channel carrying one line pair per beat.
interface slcm_in_if import slcm_pkg::*; ();
    logic       valid;
    logic       ready;
    t_line_pair payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ src/slcm_out_if.sv @@
// Output channel carrying one midpoint per beat.
interface slcm_out_if import slcm_pkg::*; ();
    logic valid;
    logic ready;
    t_mid payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ src/slcm_mul.sv @@
// Pipelined signed multiplier built from 32-bit limb partial products.
module slcm_mul import slcm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic signed [MUL_PW-1:0] o_p
);

    localparam int NPAIR  = (MUL_LIMBS + 1) / 2;
    localparam int NPP    = 2 * NPAIR;
    localparam int MA_W   = NPP * LIMB_W;
    localparam int PP_W   = LIMB_W + MUL_BW;
    localparam int PAIR_W = 2 * LIMB_W + MUL_BW + 1;

    logic [MA_W-1:0]   r_ma;
    logic [MUL_BW-1:0] r_mb;
    logic [PP_W-1:0]   r_pp [NPP];
    logic [PAIR_W-1:0] r_pair [NPAIR];
    logic [MUL_PW-1:0] r_mag;
    logic [3:0]        r_neg;
    logic [MUL_PW-1:0] n_mag;

    // Add the limb pairs at their weights.
    always_comb begin
        n_mag = '0;
        for (int j = 0; j < NPAIR; j++) begin
            n_mag = n_mag + (MUL_PW'(r_pair[j]) << (2 * LIMB_W * j));
        end
    end

    // Magnitudes, limb products, pair sums, total, sign.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= MA_W'($unsigned(i_a[MUL_AW-1] ? -i_a : i_a));
            r_mb  <= $unsigned(i_b[MUL_BW-1] ? -i_b : i_b);
            r_neg <= {r_neg[2:0], i_a[MUL_AW-1] ^ i_b[MUL_BW-1]};
            for (int i = 0; i < NPP; i++) begin
                r_pp[i] <= {{MUL_BW{1'b0}}, r_ma[i*LIMB_W +: LIMB_W]} *
                           {{LIMB_W{1'b0}}, r_mb};
            end
            for (int j = 0; j < NPAIR; j++) begin
                r_pair[j] <= PAIR_W'(r_pp[2*j]) + (PAIR_W'(r_pp[2*j+1]) << LIMB_W);
            end
            r_mag <= n_mag;
            o_p   <= r_neg[3] ? -$signed(r_mag) : $signed(r_mag);
        end
    end

endmodule

@@ src/slcm_div.sv @@
// Pipelined restoring divider: floor quotient with overflow detection, one bit per stage.
module slcm_div import slcm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W:0]          i_den2,
    output logic signed [QB+1:0]    o_q,
    output logic                    o_ovf,
    output logic                    o_neg
);

    localparam int DV_W = NUM_W + 1;

    logic [DV_W-1:0] r_m;
    logic [DEN_W:0]  r_d0;
    logic            r_n0;
    logic [DV_W-1:0] r_rem [0:QB];
    logic [QB-1:0]   r_qt  [0:QB];
    logic [DEN_W:0]  r_dv  [0:QB];
    logic            r_ng  [0:QB];
    logic            r_ov  [0:QB];
    logic [DV_W-1:0] trial [QB];

    // Shifted divisor tried at each stage.
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            trial[k] = DV_W'(r_dv[k]) << (QB - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Magnitude of the numerator.
            r_m  <= DV_W'($unsigned(i_num[NUM_W-1] ? -i_num : i_num));
            r_d0 <= i_den2;
            r_n0 <= i_num[NUM_W-1];
            // A quotient that does not fit the kept bits saturates.
            r_rem[0] <= r_m;
            r_qt[0]  <= '0;
            r_dv[0]  <= r_d0;
            r_ng[0]  <= r_n0;
            r_ov[0]  <= r_m >= (DV_W'(r_d0) << QB);
            // One quotient bit per stage, most significant first.
            for (int k = 0; k < QB; k++) begin
                r_dv[k+1] <= r_dv[k];
                r_ng[k+1] <= r_ng[k];
                r_ov[k+1] <= r_ov[k];
                if (r_rem[k] >= trial[k]) begin
                    r_rem[k+1] <= r_rem[k] - trial[k];
                    r_qt[k+1]  <= r_qt[k] | (QB'(1) << (QB - 1 - k));
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_qt[k+1]  <= r_qt[k];
                end
            end
            // A negative numerator rounds the magnitude up before negation.
            if (r_ng[QB]) begin
                o_q <= -((QB+2)'(r_qt[QB]) + (QB+2)'(r_rem[QB] != '0));
            end else begin
                o_q <= (QB+2)'(r_qt[QB]);
            end
            o_ovf <= r_ov[QB];
            o_neg <= r_ng[QB];
        end
    end

endmodule

@@ src/skew_line_closest_midpoint_unit.sv @@
// Top level of the skew line closest-approach midpoint unit.
//
// Usage: each beat on i_line carries two 3D lines (start point and direction,
// signed Q16.16). Each beat on o_mid returns the midpoint of the common
// perpendicular, rounded to the nearest step and saturated, or zeros with
// parallel set when the direction cross product vanishes.
// Both channels use valid/ready; a beat moves when both are high.
// Throughput: one beat per cycle while the skid slot is free. The pipeline is
// set by three chained multiplier groups of five stages each
// and a divider that resolves one quotient bit per stage (34 bits).
// Reset (synchronous, active low) clears every valid bit, the output valid and
// the skid flag; no item is in flight afterwards.
// When the receiver stalls, the pipeline keeps moving into one skid slot;
// i_line.ready drops only once that slot holds a waiting beat, and the
// pipeline then freezes with nothing lost or repeated.
`include "skew_line_closest_midpoint_unit_macros.svh"
module skew_line_closest_midpoint_unit import slcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slcm_in_if.sink     i_line,
    slcm_out_if.source  o_mid
);

    localparam int SW = QB + 3;
    localparam logic signed [CW-1:0] OUT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] OUT_MIN = {1'b1, {(CW-1){1'b0}}};

    logic en;

    // Valid bits and payload registers of the main pipeline.
    logic [S_OUT:0]          r_vld;
    logic signed [CW-1:0]    r_pa  [0:S_OUT-1][3];
    logic signed [CW-1:0]    r_da  [0:S_SUM2][3];
    logic signed [CW-1:0]    r_db0 [3];
    logic signed [BA_W-1:0]  r_ba  [0:S_W][3];
    logic signed [W_W-1:0]   r_w   [S_W:S_SUM2][3];
    logic signed [X_W-1:0]   r_x   [3];
    logic                    r_par [S_W:S_OUT-1];
    logic [DEN_W-1:0]        r_ww  [3];
    logic signed [SX_W-1:0]  r_xw  [3];
    logic signed [SB_W-1:0]  r_bw  [3];
    logic [DEN_W-1:0]        r_den [S_SUM2:S_NUM];
    logic signed [SX_W-1:0]  r_sx;
    logic signed [SB_W-1:0]  r_sb;
    logic signed [NUM_W-1:0] r_n   [3];
    logic signed [NUM_W-1:0] r_num [3];
    t_mid                    r_res;

    // Output register and skid slot.
    t_mid r_o;
    t_mid r_skid;
    logic r_ov;
    logic r_skid_v;

    // Inputs as per-axis arrays.
    logic signed [CW-1:0] in_pa [3];
    logic signed [CW-1:0] in_da [3];
    logic signed [CW-1:0] in_pb [3];
    logic signed [CW-1:0] in_db [3];

    // Multiplier results.
    logic signed [MUL_PW-1:0] p_w0 [3];
    logic signed [MUL_PW-1:0] p_w1 [3];
    logic signed [MUL_PW-1:0] p_x0 [3];
    logic signed [MUL_PW-1:0] p_x1 [3];
    logic signed [MUL_PW-1:0] p_dl [3];
    logic signed [MUL_PW-1:0] p_dh [3];
    logic signed [MUL_PW-1:0] p_sl [3];
    logic signed [MUL_PW-1:0] p_sh [3];
    logic signed [MUL_PW-1:0] p_b  [3];
    logic signed [MUL_PW-1:0] p_t  [3];
    logic signed [MUL_PW-1:0] p_ul [3];
    logic signed [MUL_PW-1:0] p_uh [3];

    // Divider results.
    logic signed [QB+1:0] q_d   [3];
    logic                 ovf_d [3];
    logic                 neg_d [3];

    logic signed [W_W-1:0] n_w   [3];
    logic signed [SW-1:0]  n_sum [3];
    t_mid                  n_res;

    // The pipeline moves whenever the skid slot is free.
    assign en           = !r_skid_v;
    assign i_line.ready = en;

    always_comb begin
        in_pa[0] = i_line.payload.line_a_start_x;
        in_pa[1] = i_line.payload.line_a_start_y;
        in_pa[2] = i_line.payload.line_a_start_z;
        in_da[0] = i_line.payload.line_a_dir_x;
        in_da[1] = i_line.payload.line_a_dir_y;
        in_da[2] = i_line.payload.line_a_dir_z;
        in_pb[0] = i_line.payload.line_b_start_x;
        in_pb[1] = i_line.payload.line_b_start_y;
        in_pb[2] = i_line.payload.line_b_start_z;
        in_db[0] = i_line.payload.line_b_dir_x;
        in_db[1] = i_line.payload.line_b_dir_y;
        in_db[2] = i_line.payload.line_b_dir_z;
    end

    // Multiplier groups, one set per axis.
    for (genvar k = 0; k < 3; k++) begin : g_axis
        localparam int KA = (k + 1) % 3;
        localparam int KB = (k + 2) % 3;

        // Cross products w = da x db and x = (B - A) x db.
        slcm_mul u_w0 (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_da[0][KA])),
                       .i_b(MUL_BW'(r_db0[KB])), .o_p(p_w0[k]));
        slcm_mul u_w1 (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_da[0][KB])),
                       .i_b(MUL_BW'(r_db0[KA])), .o_p(p_w1[k]));
        slcm_mul u_x0 (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_ba[0][KA])),
                       .i_b(MUL_BW'(r_db0[KB])), .o_p(p_x0[k]));
        slcm_mul u_x1 (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_ba[0][KB])),
                       .i_b(MUL_BW'(r_db0[KA])), .o_p(p_x1[k]));

        // Dot product terms w.w, x.w and (B - A).w; w splits into two digits.
        slcm_mul u_dl (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_w[S_W][k])),
                       .i_b({1'b0, r_w[S_W][k][W_LO-1:0]}), .o_p(p_dl[k]));
        slcm_mul u_dh (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_w[S_W][k])),
                       .i_b(r_w[S_W][k][W_W-1:W_LO]), .o_p(p_dh[k]));
        slcm_mul u_sl (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_x[k])),
                       .i_b({1'b0, r_w[S_W][k][W_LO-1:0]}), .o_p(p_sl[k]));
        slcm_mul u_sh (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_x[k])),
                       .i_b(r_w[S_W][k][W_W-1:W_LO]), .o_p(p_sh[k]));
        slcm_mul u_b  (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_w[S_W][k])),
                       .i_b(MUL_BW'(r_ba[S_W][k])), .o_p(p_b[k]));

        // Numerator terms da*sx and sb*w.
        slcm_mul u_t  (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_sx)),
                       .i_b(MUL_BW'(r_da[S_SUM2][k])), .o_p(p_t[k]));
        slcm_mul u_ul (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_sb)),
                       .i_b({1'b0, r_w[S_SUM2][k][W_LO-1:0]}), .o_p(p_ul[k]));
        slcm_mul u_uh (.i_clk(i_clk), .i_en(en), .i_a(MUL_AW'(r_sb)),
                       .i_b(r_w[S_SUM2][k][W_W-1:W_LO]), .o_p(p_uh[k]));

        // Floor division by twice |w|^2.
        slcm_div u_div (.i_clk(i_clk), .i_en(en), .i_num(r_num[k]),
                        .i_den2({r_den[S_NUM], 1'b0}), .o_q(q_d[k]),
                        .o_ovf(ovf_d[k]), .o_neg(neg_d[k]));
    end

    // Cross product differences and the final add with saturation.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_w[k]   = W_W'(p_w0[k] - p_w1[k]);
            n_sum[k] = SW'(r_pa[S_OUT-1][k]) + SW'(q_d[k]);
        end
        n_res.parallel = r_par[S_OUT-1];
        n_res.mid_x    = '0;
        n_res.mid_y    = '0;
        n_res.mid_z    = '0;
        for (int k = 0; k < 3; k++) begin
            logic signed [CW-1:0] c;
            if (r_par[S_OUT-1]) begin
                c = '0;
            end else if (ovf_d[k]) begin
                c = neg_d[k] ? OUT_MIN : OUT_MAX;
            end else if (n_sum[k] > SW'(OUT_MAX)) begin
                c = OUT_MAX;
            end else if (n_sum[k] < SW'(OUT_MIN)) begin
                c = OUT_MIN;
            end else begin
                c = n_sum[k][CW-1:0];
            end
            unique case (k)
                0:       n_res.mid_x = c;
                1:       n_res.mid_y = c;
                default: n_res.mid_z = c;
            endcase
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[S_OUT-1:0], i_line.valid};
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_pa[0][k] <= in_pa[k];
                r_da[0][k] <= in_da[k];
                r_db0[k]   <= in_db[k];
                r_ba[0][k] <= BA_W'(in_pb[k]) - BA_W'(in_pa[k]);
            end
            for (int s = 1; s < S_OUT; s++) r_pa[s] <= r_pa[s-1];
            for (int s = 1; s <= S_SUM2; s++) r_da[s] <= r_da[s-1];
            for (int s = 1; s <= S_W; s++) r_ba[s] <= r_ba[s-1];
            for (int s = S_W + 1; s <= S_SUM2; s++) r_w[s] <= r_w[s-1];
            for (int s = S_W + 1; s < S_OUT; s++) r_par[s] <= r_par[s-1];
            for (int s = S_SUM2 + 1; s <= S_NUM; s++) r_den[s] <= r_den[s-1];

            // Cross products; zero w marks parallel or degenerate lines.
            for (int k = 0; k < 3; k++) begin
                r_w[S_W][k] <= n_w[k];
                r_x[k]      <= X_W'(p_x0[k] - p_x1[k]);
            end
            r_par[S_W] <= (n_w[0] == '0) && (n_w[1] == '0) && (n_w[2] == '0);

            // Recombine the split-digit products, then sum over the axes.
            for (int k = 0; k < 3; k++) begin
                r_ww[k] <= DEN_W'((p_dh[k] <<< W_LO) + p_dl[k]);
                r_xw[k] <= SX_W'((p_sh[k] <<< W_LO) + p_sl[k]);
                r_bw[k] <= SB_W'(p_b[k]);
            end
            r_den[S_SUM2] <= r_ww[0] + r_ww[1] + r_ww[2];
            r_sx          <= r_xw[0] + r_xw[1] + r_xw[2];
            r_sb          <= r_bw[0] + r_bw[1] + r_bw[2];

            // Numerator 2*da*sx + sb*w, then the rounding offset |w|^2.
            for (int k = 0; k < 3; k++) begin
                r_n[k]   <= NUM_W'(p_t[k] <<< 1) + NUM_W'(p_uh[k] <<< W_LO) +
                            NUM_W'(p_ul[k]);
                r_num[k] <= r_n[k] + $signed(NUM_W'(r_den[S_N]));
            end

            r_res <= n_res;
        end
    end

    // Output register with one skid slot behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (r_ov && !o_mid.ready) begin
                if (r_vld[S_OUT]) begin
                    r_skid_v <= 1'b1;
                end
            end else begin
                r_ov <= r_vld[S_OUT];
            end
        end else if (o_mid.ready) begin
            r_ov     <= 1'b1;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (r_ov && !o_mid.ready) begin
                r_skid <= r_res;
            end else begin
                r_o <= r_res;
            end
        end else if (o_mid.ready) begin
            r_o <= r_skid;
        end
    end

    assign o_mid.valid   = r_ov;
    assign o_mid.payload = r_o;

    // A beat in the skid slot always has one in front of it.
    `SLCM_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_ov)
    // The skid slot holds while the receiver stalls.
    `SLCM_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_v && !o_mid.ready, r_skid_v)
    // A finished beat meeting a stalled output goes to the skid slot.
    `SLCM_ASSERT_NEXT(a_skid_catches, i_clk, i_rst_n,
        r_vld[S_OUT] && !r_skid_v && r_ov && !o_mid.ready, r_skid_v)
    // Parallel results carry a zero midpoint.
    `SLCM_ASSERT_NOW(a_parallel_zero, i_clk, i_rst_n, r_ov && r_o.parallel,
        (r_o.mid_x == '0) && (r_o.mid_y == '0) && (r_o.mid_z == '0))

endmodule

@@ test/tb_skew_line_closest_midpoint_unit.sv @@
// Self-checking testbench for the skew line closest-approach midpoint unit.
`timescale 1ns / 1ps

module tb_skew_line_closest_midpoint_unit;
    import slcm_pkg::*;

    typedef logic signed [255:0] big_t;

    // Scoreboard: predicts each midpoint from the accepted line pair and checks results.
    class midpoint_scoreboard;
        t_mid pending_mids[$];
        int   mismatches;
        int   checked;
        int   parallel_seen;
        int   saturated_seen;

        function new();
            mismatches = 0;
            checked = 0;
            parallel_seen = 0;
            saturated_seen = 0;
        endfunction

        // Rounds num / (2 * den) exactly to the nearest raw step with ties upward, adds base, then clamps.
        function logic [CW-1:0] round_clamp(big_t base, big_t num, big_t den);
            big_t a;
            big_t q;
            big_t v;
            big_t maxc;
            big_t minc;
            a = num + den;
            q = a / (den + den);
            if (a < 0 && q * (den + den) != a) q = q - 1;
            v = base + q;
            maxc = big_t'(2147483647);
            minc = -maxc - 1;
            if (v > maxc) begin
                v = maxc;
                saturated_seen++;
            end else if (v < minc) begin
                v = minc;
                saturated_seen++;
            end
            return v[CW-1:0];
        endfunction

        function t_mid predict_midpoint(t_line_pair p);
            big_t pa[3], da[3], pb[3], db[3], w[3], x[3], ba[3];
            big_t den, sx, sy, num;
            t_mid m;
            pa[0] = big_t'(p.line_a_start_x); pa[1] = big_t'(p.line_a_start_y);
            pa[2] = big_t'(p.line_a_start_z);
            da[0] = big_t'(p.line_a_dir_x);   da[1] = big_t'(p.line_a_dir_y);
            da[2] = big_t'(p.line_a_dir_z);
            pb[0] = big_t'(p.line_b_start_x); pb[1] = big_t'(p.line_b_start_y);
            pb[2] = big_t'(p.line_b_start_z);
            db[0] = big_t'(p.line_b_dir_x);   db[1] = big_t'(p.line_b_dir_y);
            db[2] = big_t'(p.line_b_dir_z);
            w[0] = da[1] * db[2] - da[2] * db[1];
            w[1] = da[2] * db[0] - da[0] * db[2];
            w[2] = da[0] * db[1] - da[1] * db[0];
            den = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
            m = '0;
            if (den == 0) begin
                m.parallel = 1'b1;
                return m;
            end
            for (int k = 0; k < 3; k++) ba[k] = pb[k] - pa[k];
            x[0] = ba[1] * db[2] - ba[2] * db[1];
            x[1] = ba[2] * db[0] - ba[0] * db[2];
            x[2] = ba[0] * db[1] - ba[1] * db[0];
            sx = x[0] * w[0] + x[1] * w[1] + x[2] * w[2];
            sy = -(ba[0] * w[0] + ba[1] * w[1] + ba[2] * w[2]);
            num = 2 * da[0] * sx - sy * w[0];
            m.mid_x = round_clamp(pa[0], num, den);
            num = 2 * da[1] * sx - sy * w[1];
            m.mid_y = round_clamp(pa[1], num, den);
            num = 2 * da[2] * sx - sy * w[2];
            m.mid_z = round_clamp(pa[2], num, den);
            return m;
        endfunction

        function void note_pair(t_line_pair p);
            t_mid m;
            m = predict_midpoint(p);
            if (m.parallel) parallel_seen++;
            pending_mids.push_back(m);
        endfunction

        function void check_mid(t_mid got);
            t_mid exp_mid;
            checked++;
            if (pending_mids.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: midpoint beat with nothing pending: %h", got);
                return;
            end
            exp_mid = pending_mids.pop_front();
            if (got !== exp_mid) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: mid exp x=%h y=%h z=%h par=%b got x=%h y=%h z=%h par=%b",
                             exp_mid.mid_x, exp_mid.mid_y, exp_mid.mid_z, exp_mid.parallel,
                             got.mid_x, got.mid_y, got.mid_z, got.parallel);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    slcm_in_if  line_if();
    slcm_out_if mid_if();

    skew_line_closest_midpoint_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_if),
        .o_mid   (mid_if)
    );

    midpoint_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls plus a long hold-off counted in cycles here.
    initial begin
        int hold_left;
        hold_left = 0;
        mid_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                mid_if.ready <= 1'b0;
            end else begin
                mid_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Input and output monitors sample the values that held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && line_if.valid && line_if.ready) sb.note_pair(line_if.payload);
        if (i_rst_n && mid_if.valid && mid_if.ready) sb.check_mid(mid_if.payload);
    end

    // Offers one line pair after a random gap and waits for its beat.
    task automatic send_pair(t_line_pair p);
        while ($urandom_range(99) < sender_idle_pct) begin
            line_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        line_if.valid <= 1'b1;
        line_if.payload <= p;
        do @(posedge i_clk); while (!line_if.ready);
    endtask

    function automatic logic [31:0] pick_coord(int style);
        case (style)
            0: return $urandom();
            1: return 32'($signed($urandom_range(65535 * 16)) - 65535 * 8);
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(200)) - 100) << 16;
        endcase
    endfunction

    // Random pair; some have parallel or zero directions.
    function automatic t_line_pair random_pair();
        t_line_pair p;
        int style;
        int kind;
        logic signed [31:0] k;
        style = $urandom_range(9) < 4 ? 0 : ($urandom_range(9) < 8 ? 1 : $urandom_range(3));
        p.line_a_start_x = pick_coord(style); p.line_a_start_y = pick_coord(style);
        p.line_a_start_z = pick_coord(style); p.line_a_dir_x = pick_coord(style);
        p.line_a_dir_y = pick_coord(style);   p.line_a_dir_z = pick_coord(style);
        p.line_b_start_x = pick_coord(style); p.line_b_start_y = pick_coord(style);
        p.line_b_start_z = pick_coord(style); p.line_b_dir_x = pick_coord(style);
        p.line_b_dir_y = pick_coord(style);   p.line_b_dir_z = pick_coord(style);
        kind = $urandom_range(19);
        if (kind == 0) begin
            k = $signed($urandom_range(6)) - 3;
            p.line_a_dir_x = $signed($urandom_range(2000)) - 1000;
            p.line_a_dir_y = $signed($urandom_range(2000)) - 1000;
            p.line_a_dir_z = $signed($urandom_range(2000)) - 1000;
            p.line_b_dir_x = p.line_a_dir_x * k;
            p.line_b_dir_y = p.line_a_dir_y * k;
            p.line_b_dir_z = p.line_a_dir_z * k;
        end else if (kind == 1) begin
            p.line_b_dir_x = '0; p.line_b_dir_y = '0; p.line_b_dir_z = '0;
        end
        return p;
    endfunction

    function automatic t_line_pair make_pair(logic [31:0] ax, ay, az, adx, ady, adz,
                                             bx, by, bz, bdx, bdy, bdz);
        t_line_pair p;
        p = {ax, ay, az, adx, ady, adz, bx, by, bz, bdx, bdy, bdz};
        return p;
    endfunction

    initial begin
        int waited;
        bit timed_out;
        t_line_pair p;
        sb = new();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_request = 0;
        timed_out = 0;
        i_rst_n = 1'b0;
        line_if.valid = 1'b0;
        line_if.payload = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs: zero and full-scale values, degenerate and parallel lines.
        send_pair('0);
        send_pair({12{32'h7fff_ffff}});
        send_pair({12{32'h8000_0000}});
        send_pair({12{32'hffff_ffff}});
        send_pair(make_pair(0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0));
        send_pair(make_pair(1, 2, 3, 4, 5, 6, 7, 8, 9, 8, 10, 12));
        send_pair(make_pair(5, 5, 5, 0, 0, 0, 1, 1, 1, 3, 4, 5));
        send_pair(make_pair(32'h7fff_0000, 32'h8000_0000, 0, 1, 0, 0,
                            32'h8000_0000, 32'h7fff_ffff, 0, 0, 1, 1));
        send_pair(make_pair(0, 0, 0, 1, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            0, 1, 0));
        send_pair(make_pair(0, 0, 0, 1, 1, 0, 3, 0, 1, 1, 32'hffff_ffff, 0));
        send_pair(make_pair(0, 0, 0, 1, 0, 0, 1, 0, 1, 0, 1, 0));
        send_pair(make_pair(32'h8000_0000, 0, 0, 32'h7fff_ffff, 1, 0,
                            32'h7fff_ffff, 0, 0, 1, 32'h8000_0000, 1));
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 0,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 1, 1));
        send_pair(make_pair(0, 0, 0, 2, 4, 6, 9, 9, 9, 32'hffff_fffe, 32'hffff_fffc,
                            32'hffff_fffa));

        // Four idling phases; the first also holds the receiver off for a long stretch.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  hold_request = 300; end
                1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
                default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
            endcase
            for (int n = 0; n < 310; n++) begin
                p = random_pair();
                send_pair(p);
                // The gap is never empty, so valid is driven once per edge.
                if ($urandom_range(49) == 0) begin
                    line_if.valid <= 1'b0;
                    repeat ($urandom_range(80) + 1) @(posedge i_clk);
                end
            end
        end
        line_if.valid <= 1'b0;

        // Drain every pending midpoint, then let the pipeline settle.
        waited = 0;
        while (sb.pending_mids.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        timed_out = (sb.pending_mids.size() != 0);
        repeat (100) @(posedge i_clk);

        $display("Checked %0d midpoints (%0d parallel, %0d saturated coordinates),",
                 sb.checked, sb.parallel_seen, sb.saturated_seen);
        $display("over four idling phases with a long receiver hold-off; %0d mismatches.",
                 sb.mismatches);
        if (timed_out || sb.mismatches != 0 || sb.pending_mids.size() != 0) begin
            $display("CHECK FAILED");
        end else begin
            $display("CHECK OK");
        end
        $finish;
    end
endmodule
